### hw/rtl/jbt_pkg.sv
package jbt_pkg;

  // Width of the internal byte counter; offsets wrap at this width.
  localparam int POS_BITS = 32;

  localparam int MAX_RESULTS = 3;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  // Token kinds
  localparam logic [3:0] KIND_LBRACKET = 4'd0;
  localparam logic [3:0] KIND_RBRACKET = 4'd1;
  localparam logic [3:0] KIND_LBRACE   = 4'd2;
  localparam logic [3:0] KIND_RBRACE   = 4'd3;
  localparam logic [3:0] KIND_COMMA    = 4'd4;
  localparam logic [3:0] KIND_COLON    = 4'd5;
  localparam logic [3:0] KIND_STRING   = 4'd6;
  localparam logic [3:0] KIND_INTEGER  = 4'd7;
  localparam logic [3:0] KIND_NUMBER   = 4'd8;
  localparam logic [3:0] KIND_TRUE     = 4'd9;
  localparam logic [3:0] KIND_FALSE    = 4'd10;
  localparam logic [3:0] KIND_NULL     = 4'd11;
  localparam logic [3:0] KIND_END      = 4'd12;

  // Keyword slots (bit positions in the candidate mask)
  localparam logic [1:0] KW_NULL  = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_TRUE  = 2'd2;
  localparam int         KW_COUNT = 3;

  // Characters
  localparam logic [7:0] CH_0        = "0";
  localparam logic [7:0] CH_9        = "9";
  localparam logic [7:0] CH_DOT      = ".";
  localparam logic [7:0] CH_MINUS    = "-";
  localparam logic [7:0] CH_USCORE   = "_";
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_LBRACKET = "[";
  localparam logic [7:0] CH_RBRACKET = "]";
  localparam logic [7:0] CH_LBRACE   = "{";
  localparam logic [7:0] CH_RBRACE   = "}";
  localparam logic [7:0] CH_COMMA    = ",";
  localparam logic [7:0] CH_COLON    = ":";

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         token_kind;
    logic [31:0]        token_start;
    logic [31:0]        token_end;
    logic signed [63:0] integer_value;
    logic               error_code;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0]                        count;
    out_item_t [MAX_RESULTS-1:0]       items;
  } burst_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_run_byte(input logic [7:0] c);
    return is_digit(c) || (c == CH_DOT) || (c == CH_MINUS);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == CH_USCORE);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  // {hit, kind}
  function automatic logic [4:0] punct_code(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    unique case (c)
      CH_LBRACKET: r = {1'b1, KIND_LBRACKET};
      CH_RBRACKET: r = {1'b1, KIND_RBRACKET};
      CH_LBRACE:   r = {1'b1, KIND_LBRACE};
      CH_RBRACE:   r = {1'b1, KIND_RBRACE};
      CH_COMMA:    r = {1'b1, KIND_COMMA};
      CH_COLON:    r = {1'b1, KIND_COLON};
      default:     r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
    logic [7:0] r;
    r = 8'h00;
    unique case (k)
      KW_NULL: begin
        case (idx)
          3'd0:    r = "n";
          3'd1:    r = "u";
          3'd2:    r = "l";
          3'd3:    r = "l";
          default: r = 8'h00;
        endcase
      end
      KW_FALSE: begin
        case (idx)
          3'd0:    r = "f";
          3'd1:    r = "a";
          3'd2:    r = "l";
          3'd3:    r = "s";
          3'd4:    r = "e";
          default: r = 8'h00;
        endcase
      end
      KW_TRUE: begin
        case (idx)
          3'd0:    r = "t";
          3'd1:    r = "r";
          3'd2:    r = "u";
          3'd3:    r = "e";
          default: r = 8'h00;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    return (k == KW_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [3:0] kw_kind(input logic [1:0] k);
    logic [3:0] r;
    r = KIND_STRING;
    unique case (k)
      KW_NULL:  r = KIND_NULL;
      KW_FALSE: r = KIND_FALSE;
      KW_TRUE:  r = KIND_TRUE;
      default:  r = KIND_STRING;
    endcase
    return r;
  endfunction

  // Offsets leave the block as their low 32 bits.
  function automatic logic [31:0] pos_out(input logic [POS_BITS-1:0] p);
    logic [63:0] w;
    w = 64'(p);
    return w[31:0];
  endfunction

endpackage

### hw/rtl/jbt_lexer.sv
module jbt_lexer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  jbt_pkg::in_item_t item,
  output jbt_pkg::burst_t   burst
);

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_STRING = 2'd1;
  localparam logic [1:0] MODE_RUN    = 2'd2;
  localparam logic [1:0] MODE_WORD   = 2'd3;

  localparam int PB = jbt_pkg::POS_BITS;

  typedef struct packed {
    logic [63:0] acc;
    logic        stopped;
    logic        dot;
  } run_t;

  typedef struct packed {
    logic [2:0] len;
    logic [2:0] cand;
  } word_t;

  logic [1:0]    mode_r,    mode_nxt;
  logic [PB-1:0] pos_r,     pos_nxt;
  logic [PB-1:0] start_r,   start_nxt;
  logic [63:0]   acc_r,     acc_nxt;
  logic          neg_r,     neg_nxt;
  logic          stopped_r, stopped_nxt;
  logic          dot_r,     dot_nxt;
  logic [2:0]    wlen_r,    wlen_nxt;
  logic [2:0]    cand_r,    cand_nxt;
  logic          err_r,     err_nxt;

  function automatic run_t run_add(input run_t s, input logic [7:0] c);
    run_t r;
    r = s;
    if (c == jbt_pkg::CH_DOT) r.dot = 1'b1;
    if (!s.stopped && jbt_pkg::is_digit(c)) begin
      r.acc = (s.acc << 3) + (s.acc << 1) + 64'(c[3:0]);
    end else begin
      r.stopped = 1'b1;
    end
    return r;
  endfunction

  function automatic word_t word_add(input word_t s, input logic [7:0] c);
    word_t r;
    r = s;
    for (int i = 0; i < jbt_pkg::KW_COUNT; i++) begin
      if ((s.len >= jbt_pkg::kw_len(2'(i))) || (jbt_pkg::kw_char(2'(i), s.len) != c)) begin
        r.cand[i] = 1'b0;
      end
    end
    if (s.len != 3'd7) r.len = s.len + 3'd1;
    return r;
  endfunction

  function automatic jbt_pkg::out_item_t mk_item(input logic [3:0] kind,
                                                 input logic [PB-1:0] s,
                                                 input logic [PB-1:0] e,
                                                 input logic [63:0] v,
                                                 input logic err);
    jbt_pkg::out_item_t r;
    r.token_kind    = kind;
    r.token_start   = jbt_pkg::pos_out(s);
    r.token_end     = jbt_pkg::pos_out(e);
    r.integer_value = v;
    r.error_code    = err;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  // Close the pending run, word or string.
  function automatic jbt_pkg::out_item_t flush_item(input logic [1:0] m,
                                                    input run_t rs, input logic neg,
                                                    input word_t ws,
                                                    input logic [PB-1:0] s,
                                                    input logic [PB-1:0] e,
                                                    input logic err);
    logic [3:0]  kind;
    logic [63:0] v;
    kind = jbt_pkg::KIND_STRING;
    v    = 64'd0;
    if (m == MODE_RUN) begin
      if (rs.dot) begin
        kind = jbt_pkg::KIND_NUMBER;
      end else begin
        kind = jbt_pkg::KIND_INTEGER;
        v    = neg ? (64'd0 - rs.acc) : rs.acc;
      end
    end else if (m == MODE_WORD) begin
      for (int i = 0; i < jbt_pkg::KW_COUNT; i++) begin
        if (ws.cand[i] && (ws.len == jbt_pkg::kw_len(2'(i)))) kind = jbt_pkg::kw_kind(2'(i));
      end
    end
    return mk_item(kind, s, e, v, err);
  endfunction

  always_comb begin : step_logic
    logic [7:0]    c;
    logic [4:0]    pk;
    logic [PB-1:0] p;
    logic [PB-1:0] nx;
    logic          handled;
    logic [1:0]    n;
    run_t          rs;
    word_t         ws;
    jbt_pkg::out_item_t [jbt_pkg::MAX_RESULTS-1:0] items;

    c       = item.text_byte;
    pk      = jbt_pkg::punct_code(c);
    p       = pos_r;
    nx      = p + PB'(1);
    handled = 1'b0;
    n       = 2'd0;
    items   = '0;

    mode_nxt  = mode_r;
    start_nxt = start_r;
    neg_nxt   = neg_r;
    err_nxt   = err_r;
    rs        = '{acc: acc_r, stopped: stopped_r, dot: dot_r};
    ws        = '{len: wlen_r, cand: cand_r};

    if ((mode_r != MODE_STRING) && !pk[4] && (c != jbt_pkg::CH_QUOTE)
        && !jbt_pkg::is_run_byte(c) && !jbt_pkg::is_letter(c) && !jbt_pkg::is_space(c)) begin
      err_nxt = 1'b1;
    end

    unique case (mode_r)
      MODE_IDLE: begin
      end
      MODE_STRING: begin
        if (c == jbt_pkg::CH_QUOTE) begin
          items[n] = mk_item(jbt_pkg::KIND_STRING, start_nxt, p, 64'd0, err_nxt);
          n        = n + 2'd1;
          mode_nxt = MODE_IDLE;
        end
        handled = 1'b1;
      end
      MODE_RUN: begin
        if (jbt_pkg::is_run_byte(c)) begin
          rs      = run_add(rs, c);
          handled = 1'b1;
        end else begin
          items[n] = flush_item(mode_nxt, rs, neg_nxt, ws, start_nxt, p, err_nxt);
          n        = n + 2'd1;
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_WORD: begin
        if (jbt_pkg::is_letter(c) || jbt_pkg::is_digit(c)) begin
          ws      = word_add(ws, c);
          handled = 1'b1;
        end else begin
          items[n] = flush_item(mode_nxt, rs, neg_nxt, ws, start_nxt, p, err_nxt);
          n        = n + 2'd1;
          mode_nxt = MODE_IDLE;
        end
      end
    endcase

    if (!handled) begin
      if (pk[4]) begin
        items[n] = mk_item(pk[3:0], p, p, 64'd0, err_nxt);
        n        = n + 2'd1;
      end else if (c == jbt_pkg::CH_QUOTE) begin
        mode_nxt  = MODE_STRING;
        start_nxt = nx;
      end else if (jbt_pkg::is_run_byte(c)) begin
        mode_nxt  = MODE_RUN;
        start_nxt = p;
        rs        = '0;
        neg_nxt   = (c == jbt_pkg::CH_MINUS);
        if (!neg_nxt) rs = run_add(rs, c);
      end else if (jbt_pkg::is_letter(c)) begin
        mode_nxt  = MODE_WORD;
        start_nxt = p;
        ws        = '{len: 3'd0, cand: 3'b111};
        ws        = word_add(ws, c);
      end
    end

    pos_nxt = nx;

    // End of document: flush, mark the end, return to reset values.
    if (item.end_of_input) begin
      if (mode_nxt != MODE_IDLE) begin
        items[n] = flush_item(mode_nxt, rs, neg_nxt, ws, start_nxt, nx, err_nxt);
        n        = n + 2'd1;
      end
      items[n]  = mk_item(jbt_pkg::KIND_END, nx, nx, 64'd0, err_nxt);
      n         = n + 2'd1;
      mode_nxt  = MODE_IDLE;
      pos_nxt   = '0;
      start_nxt = '0;
      neg_nxt   = 1'b0;
      err_nxt   = 1'b0;
      rs        = '0;
      ws        = '{len: 3'd0, cand: 3'b111};
    end

    if (n != 2'd0) items[n - 2'd1].last_of_run = 1'b1;

    acc_nxt     = rs.acc;
    stopped_nxt = rs.stopped;
    dot_nxt     = rs.dot;
    wlen_nxt    = ws.len;
    cand_nxt    = ws.cand;

    burst.count = n;
    burst.items = items;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      pos_r     <= '0;
      start_r   <= '0;
      acc_r     <= '0;
      neg_r     <= 1'b0;
      stopped_r <= 1'b0;
      dot_r     <= 1'b0;
      wlen_r    <= 3'd0;
      cand_r    <= 3'b111;
      err_r     <= 1'b0;
    end else if (step_en) begin
      mode_r    <= mode_nxt;
      pos_r     <= pos_nxt;
      start_r   <= start_nxt;
      acc_r     <= acc_nxt;
      neg_r     <= neg_nxt;
      stopped_r <= stopped_nxt;
      dot_r     <= dot_nxt;
      wlen_r    <= wlen_nxt;
      cand_r    <= cand_nxt;
      err_r     <= err_nxt;
    end
  end

endmodule

### hw/rtl/jbt_result_queue.sv
module jbt_result_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_en,
  input  jbt_pkg::burst_t    burst,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output jbt_pkg::out_item_t out_data
);

  localparam int PW = jbt_pkg::QPTR_W;
  localparam int CW = jbt_pkg::QCNT_W;

  jbt_pkg::out_item_t entries_r [jbt_pkg::QDEPTH];
  logic [PW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] push_n;
  logic          pop;
  logic [PW-1:0] tail;

  assign room      = count_r <= CW'(jbt_pkg::QDEPTH - jbt_pkg::MAX_RESULTS);
  assign out_valid = count_r != '0;
  assign out_data  = entries_r[head_r];
  assign pop       = out_valid && out_ready;
  assign push_n    = push_en ? CW'(burst.count) : '0;
  assign tail      = head_r + count_r[PW-1:0];
  assign head_nxt  = head_r + PW'(pop);
  assign count_nxt = count_r + push_n - CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < jbt_pkg::MAX_RESULTS; k++) begin
      if (CW'(k) < push_n) entries_r[tail + PW'(k)] <= burst.items[k];
    end
  end

endmodule

### hw/rtl/json_byte_tokenizer_top.sv
// Results of an accepted byte are registered in the result queue and offered on out_ behind any earlier results.
// Throughput: one byte per cycle; a byte yields zero to three results, which
// leave one per cycle from a four-entry result queue, so in_ready falls while
// more than one result waits (the queue must hold a full burst of three).
// Reset: synchronous, active low; clears lexer state and the queue, no sweep.
module json_byte_tokenizer_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  jbt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output jbt_pkg::out_item_t out_data
);

  // One decode pass per byte: class decode, keyword match, a x10 add for
  // digits and the negate on integer flush all sit in front of the queue.
  logic            step_en;
  jbt_pkg::burst_t burst;
  logic            room;

  // Advance lexer state only on an accepted item.
  assign step_en  = in_valid && in_ready;
  assign in_ready = room;

  jbt_lexer u_lexer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_data),
    .burst   (burst)
  );

  // Hold finished results here so input keeps flowing while output stalls, until more than one result waits.
  jbt_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (step_en),
    .burst     (burst),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/jbt_checker.sv
module jbt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input jbt_pkg::out_item_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The end marker closes the burst of its byte.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.token_kind == jbt_pkg::KIND_END) |-> out_data.last_of_run)
    else $error("end marker not last of burst");

  // Only integer tokens carry a value.
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.token_kind != jbt_pkg::KIND_INTEGER)
    |-> (out_data.integer_value == 64'sd0))
    else $error("value on non-integer token");

  // Punctuation and end marker span a single offset.
  a_point_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.token_kind <= jbt_pkg::KIND_COLON)
                  || (out_data.token_kind == jbt_pkg::KIND_END))
    |-> (out_data.token_start == out_data.token_end))
    else $error("point token with start != end");

endmodule

bind json_byte_tokenizer_top jbt_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### test/tb_json_byte_tokenizer_top.sv
`timescale 1ns / 1ps

module tb_json_byte_tokenizer_top;
  import jbt_pkg::*;

  // Stall limit for the watchdog. The count is held at zero during reset, so
  // the slowest correct stretch without any handshake is a drawn result stall
  // plus a drawn sender gap. Allow many times that.
  localparam int STALL_LIMIT  = 400;
  localparam int RANDOM_ITEMS = 230;
  // Results of a byte leave the result queue after it is taken; leave some slack.
  localparam int TAIL_CYCLES  = 8;

  typedef enum logic [1:0] {LX_IDLE, LX_STRING, LX_RUN, LX_WORD} lex_mode_e;

  typedef enum logic [2:0] {
    CL_PUNCT, CL_QUOTE, CL_DIGIT, CL_RUNSYM, CL_LETTER, CL_SPACE, CL_OTHER
  } byte_class_e;

  // One queued byte; hold makes the driver wait until every token is back.
  typedef struct packed {
    logic     hold;
    in_item_t item;
  } feed_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  json_byte_tokenizer_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // Bytes waiting to be sent, tokens waiting to come back.
  feed_t      byte_q[$];
  out_item_t  token_q[$];
  logic [7:0] doc_q[$];

  // Lexer state as the predictor sees it.
  lex_mode_e   lx_mode;
  logic [31:0] byte_pos;
  logic [31:0] tok_begin;
  logic [63:0] int_acc;
  logic        int_neg;
  logic        int_done;
  logic        has_dot;
  logic [2:0]  word_len;
  logic [2:0]  kw_mask;
  logic        err_flag;

  // Tokens produced by the byte being predicted.
  out_item_t step_tokens[MAX_RESULTS];
  int        step_n;

  int mismatches = 0;
  int sent_cnt = 0;
  int got_cnt = 0;
  int quiet = 0;
  int tx_wait = 0;
  int rx_wait = 0;
  int active_bytes = 0;
  feed_t      next_feed;
  logic       next_valid;
  out_item_t  want_tok;

  // ------------------------------------------------------------------
  // Byte classes and keyword tables
  // ------------------------------------------------------------------
  function automatic byte_class_e byte_class(input logic [7:0] c);
    byte_class_e cls;
    case (c)
      CH_LBRACKET, CH_RBRACKET, CH_LBRACE, CH_RBRACE, CH_COMMA, CH_COLON: cls = CL_PUNCT;
      CH_QUOTE: cls = CL_QUOTE;
      CH_DOT, CH_MINUS: cls = CL_RUNSYM;
      CH_SPACE, CH_TAB, CH_CR, CH_LF: cls = CL_SPACE;
      CH_USCORE: cls = CL_LETTER;
      default: begin
        if (c >= "0" && c <= "9") cls = CL_DIGIT;
        else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) cls = CL_LETTER;
        else cls = CL_OTHER;
      end
    endcase
    return cls;
  endfunction

  function automatic logic [3:0] punct_token(input logic [7:0] c);
    logic [3:0] k;
    case (c)
      CH_LBRACKET: k = KIND_LBRACKET;
      CH_RBRACKET: k = KIND_RBRACKET;
      CH_LBRACE:   k = KIND_LBRACE;
      CH_RBRACE:   k = KIND_RBRACE;
      CH_COMMA:    k = KIND_COMMA;
      default:     k = KIND_COLON;
    endcase
    return k;
  endfunction

  function automatic int kw_length(input int k);
    return (k == KW_FALSE) ? 5 : 4;
  endfunction

  // Keyword text, right aligned, first letter in the highest used byte.
  function automatic logic [39:0] kw_text(input int k);
    if (k == KW_NULL) return 40'("null");
    if (k == KW_FALSE) return 40'("false");
    return 40'("true");
  endfunction

  function automatic logic [3:0] kw_token(input int k);
    if (k == KW_NULL) return KIND_NULL;
    if (k == KW_FALSE) return KIND_FALSE;
    return KIND_TRUE;
  endfunction

  // ------------------------------------------------------------------
  // Token predictor
  // ------------------------------------------------------------------
  task automatic reset_lexer();
    lx_mode   = LX_IDLE;
    byte_pos  = '0;
    tok_begin = '0;
    int_acc   = '0;
    int_neg   = 1'b0;
    int_done  = 1'b0;
    has_dot   = 1'b0;
    word_len  = '0;
    kw_mask   = 3'b111;
    err_flag  = 1'b0;
  endtask

  task automatic emit_token(input logic [3:0] kind, input logic [31:0] s,
                            input logic [31:0] e, input logic [63:0] v);
    out_item_t t;
    t.token_kind    = kind;
    t.token_start   = s;
    t.token_end     = e;
    t.integer_value = v;
    t.error_code    = err_flag;
    t.last_of_run   = 1'b0;
    step_tokens[step_n] = t;
    step_n++;
  endtask

  // Extend a run of digits, dots and minus signs; the value stops at the
  // first byte that is not a digit.
  task automatic run_extend(input logic [7:0] c);
    if (c == CH_DOT) has_dot = 1'b1;
    if (!int_done && byte_class(c) == CL_DIGIT) int_acc = int_acc * 64'd10 + 64'(c - CH_0);
    else int_done = 1'b1;
  endtask

  // Drop keyword candidates that no longer match; saturate the length.
  task automatic word_extend(input logic [7:0] c);
    logic [39:0] txt;
    int          len;
    for (int k = 0; k < KW_COUNT; k++) begin
      len = kw_length(k);
      txt = kw_text(k);
      if (word_len >= len) kw_mask[k] = 1'b0;
      else if (txt[(len - 1 - word_len) * 8 +: 8] != c) kw_mask[k] = 1'b0;
    end
    if (word_len < 3'd7) word_len++;
  endtask

  task automatic flush_token(input logic [31:0] stop);
    logic [3:0]  kind;
    logic [63:0] v;
    kind = KIND_STRING;
    v    = '0;
    if (lx_mode == LX_RUN) begin
      if (has_dot) begin
        kind = KIND_NUMBER;
      end else begin
        kind = KIND_INTEGER;
        v = int_neg ? 64'd0 - int_acc : int_acc;
      end
    end else if (lx_mode == LX_WORD) begin
      for (int k = 0; k < KW_COUNT; k++)
        if (kw_mask[k] && word_len == kw_length(k)) kind = kw_token(k);
    end
    emit_token(kind, tok_begin, stop, v);
    lx_mode = LX_IDLE;
  endtask

  // Predict the tokens of one accepted byte and queue them.
  task automatic tokenize_byte(input in_item_t it);
    logic [7:0]  c;
    byte_class_e cls;
    logic [31:0] here;
    logic [31:0] after;
    logic        handled;
    c       = it.text_byte;
    cls     = byte_class(c);
    here    = byte_pos;
    after   = byte_pos + 32'd1;
    handled = 1'b0;
    step_n  = 0;

    if (lx_mode != LX_STRING && cls == CL_OTHER) err_flag = 1'b1;

    case (lx_mode)
      LX_STRING: begin
        if (cls == CL_QUOTE) begin
          emit_token(KIND_STRING, tok_begin, here, '0);
          lx_mode = LX_IDLE;
        end
        handled = 1'b1;
      end
      LX_RUN: begin
        if (cls == CL_DIGIT || cls == CL_RUNSYM) begin
          run_extend(c);
          handled = 1'b1;
        end else begin
          flush_token(here);
        end
      end
      LX_WORD: begin
        if (cls == CL_LETTER || cls == CL_DIGIT) begin
          word_extend(c);
          handled = 1'b1;
        end else begin
          flush_token(here);
        end
      end
      default: ;
    endcase

    if (!handled) begin
      case (cls)
        CL_PUNCT: emit_token(punct_token(c), here, here, '0);
        CL_QUOTE: begin
          lx_mode   = LX_STRING;
          tok_begin = after;
        end
        CL_DIGIT, CL_RUNSYM: begin
          lx_mode   = LX_RUN;
          tok_begin = here;
          int_acc   = '0;
          int_done  = 1'b0;
          has_dot   = 1'b0;
          int_neg   = (c == CH_MINUS);
          if (!int_neg) run_extend(c);
        end
        CL_LETTER: begin
          lx_mode   = LX_WORD;
          tok_begin = here;
          word_len  = '0;
          kw_mask   = 3'b111;
          word_extend(c);
        end
        default: ;
      endcase
    end

    byte_pos = after;

    // Last byte of the document: flush what is pending, mark the end, restart.
    if (it.end_of_input) begin
      if (lx_mode != LX_IDLE) flush_token(after);
      emit_token(KIND_END, after, after, '0);
      reset_lexer();
    end

    if (step_n > 0) step_tokens[step_n - 1].last_of_run = 1'b1;
    for (int i = 0; i < step_n; i++) token_q.push_back(step_tokens[i]);
  endtask

  // ------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------
  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s at result %0d: got %0h, want %0h", field, got_cnt, got, want);
    mismatches++;
  endtask

  task automatic check_token(input out_item_t got, input out_item_t want);
    if (got.token_kind !== want.token_kind)
      report_mismatch("token_kind", 64'(got.token_kind), 64'(want.token_kind));
    if (got.token_start !== want.token_start)
      report_mismatch("token_start", 64'(got.token_start), 64'(want.token_start));
    if (got.token_end !== want.token_end)
      report_mismatch("token_end", 64'(got.token_end), 64'(want.token_end));
    if (got.integer_value !== want.integer_value)
      report_mismatch("integer_value", got.integer_value, want.integer_value);
    if (got.error_code !== want.error_code)
      report_mismatch("error_code", 64'(got.error_code), 64'(want.error_code));
    if (got.last_of_run !== want.last_of_run)
      report_mismatch("last_of_run", 64'(got.last_of_run), 64'(want.last_of_run));
  endtask

  // Gap before the next item is drawn at random, except in every third stretch
  // of items, which runs with no idling at all.
  function automatic int draw_gap(input int done_cnt, input int stretch);
    if ((done_cnt / stretch) % 3 == 2) return 0;
    return $urandom_range(0, 5);
  endfunction

  // ------------------------------------------------------------------
  // Driver: take an accepted byte, predict it, then present the next one
  // after its gap. A held byte waits until every token has come back.
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        tokenize_byte(in_data);
        sent_cnt++;
        next_valid = 1'b0;
        tx_wait = draw_gap(sent_cnt, 29);
      end
      if (!next_valid) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (byte_q.size() > 0 && (!byte_q[0].hold || token_q.size() == 0)) begin
          next_feed = byte_q.pop_front();
          in_data <= next_feed.item;
          next_valid = 1'b1;
        end
      end
      in_valid <= next_valid;
    end
  end

  // ------------------------------------------------------------------
  // Monitor: compare each accepted token with the oldest prediction, then
  // stall for a drawn number of cycles.
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (token_q.size() == 0) begin
          report_mismatch("unexpected token_kind", 64'(out_data.token_kind), '0);
        end else begin
          want_tok = token_q.pop_front();
          check_token(out_data, want_tok);
        end
        got_cnt++;
        rx_wait = draw_gap(got_cnt, 37);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: count cycles without any handshake.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------
  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] pick_punct();
    case ($urandom_range(0, 5))
      0: return CH_LBRACKET;
      1: return CH_RBRACKET;
      2: return CH_LBRACE;
      3: return CH_RBRACE;
      4: return CH_COMMA;
      default: return CH_COLON;
    endcase
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'($urandom_range("0", "9"));
  endfunction

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(0, 2))
      0: return 8'($urandom_range("a", "z"));
      1: return 8'($urandom_range("A", "Z"));
      default: return CH_USCORE;
    endcase
  endfunction

  task automatic load_text(input string s);
    doc_q.delete();
    for (int i = 0; i < s.len(); i++) doc_q.push_back(s[i]);
  endtask

  // Move the document in doc_q to the send queue; its last byte ends it.
  task automatic queue_document(input logic hold);
    feed_t f;
    for (int i = 0; i < doc_q.size(); i++) begin
      f.hold = hold && (i == 0);
      f.item.text_byte = doc_q[i];
      f.item.end_of_input = (i == doc_q.size() - 1);
      byte_q.push_back(f);
      active_bytes++;
    end
  endtask

  // Build a mostly JSON-shaped document with random content, some broken
  // keywords, odd runs and stray bytes.
  task automatic gen_document(input logic hold);
    int          ntok;
    int          len;
    int          sel;
    logic [39:0] txt;
    logic [7:0]  c;
    doc_q.delete();
    ntok = $urandom_range(1, 8);
    for (int t = 0; t < ntok; t++) begin
      case ($urandom_range(0, 15))
        0, 1, 2: doc_q.push_back(pick_punct());
        3, 4: begin
          // quoted string, any byte but a quote inside; sometimes left open
          doc_q.push_back(CH_QUOTE);
          len = $urandom_range(0, 4);
          for (int i = 0; i < len; i++) begin
            c = 8'($urandom_range(0, 255));
            doc_q.push_back(c == CH_QUOTE ? 8'("q") : c);
          end
          if (t != ntok - 1 || $urandom_range(0, 3) != 0) doc_q.push_back(CH_QUOTE);
        end
        5, 6: begin
          // integer; long ones can wrap past 64 bits
          if ($urandom_range(0, 2) == 0) doc_q.push_back(CH_MINUS);
          len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 4);
          for (int i = 0; i < len; i++) doc_q.push_back(pick_digit());
        end
        7: begin
          len = $urandom_range(1, 3);
          for (int i = 0; i < len; i++) doc_q.push_back(pick_digit());
          doc_q.push_back(CH_DOT);
          len = $urandom_range(0, 3);
          for (int i = 0; i < len; i++) doc_q.push_back(pick_digit());
        end
        8: begin
          // odd run such as a lone minus, double minus or digits around a minus
          len = $urandom_range(1, 5);
          for (int i = 0; i < len; i++) begin
            sel = $urandom_range(0, 3);
            doc_q.push_back(sel == 0 ? CH_MINUS : sel == 1 ? CH_DOT : pick_digit());
          end
        end
        9, 10: begin
          // keyword, now and then truncated, extended or capitalized
          sel = $urandom_range(0, KW_COUNT - 1);
          txt = kw_text(sel);
          len = kw_length(sel);
          case ($urandom_range(0, 5))
            0: len = len - 1;
            default: ;
          endcase
          for (int i = 0; i < len; i++) begin
            c = txt[(kw_length(sel) - 1 - i) * 8 +: 8];
            doc_q.push_back(c);
          end
          case ($urandom_range(0, 5))
            0: doc_q.push_back(pick_letter());
            1: doc_q[doc_q.size() - len] = doc_q[doc_q.size() - len] - 8'd32;
            default: ;
          endcase
        end
        11: begin
          // bare word, up to well past the saturating length
          doc_q.push_back(pick_letter());
          len = $urandom_range(0, 9);
          for (int i = 0; i < len; i++)
            doc_q.push_back($urandom_range(0, 3) == 0 ? pick_digit() : pick_letter());
        end
        12: doc_q.push_back(8'($urandom_range(0, 255)));
        default: doc_q.push_back(pick_space());
      endcase
      case ($urandom_range(0, 3))
        1: doc_q.push_back(CH_COMMA);
        2: doc_q.push_back(pick_space());
        default: ;
      endcase
    end
    queue_document(hold);
  endtask

  // ------------------------------------------------------------------
  // Sequence: fill the send queue, release reset, wait for the last
  // token, then report.
  // ------------------------------------------------------------------
  initial begin
    int doc_cnt;
    reset_lexer();

    // Directed: signed integer, number, digits around a minus; string key
    // with null; stray bytes at both ends of the range, then a string
    // left open at end of input.
    load_text("[-5,2.5,5-3]");
    queue_document(1'b0);
    load_text("{\"\":null}");
    queue_document(1'b0);
    doc_q.delete();
    doc_q.push_back(8'hFF);
    doc_q.push_back(8'h00);
    doc_q.push_back(CH_QUOTE);
    doc_q.push_back(8'("x"));
    queue_document(1'b0);

    // Random documents until the item budget is used up; hold the first
    // and every third one until the block has drained.
    doc_cnt = 0;
    while (active_bytes < RANDOM_ITEMS) begin
      gen_document(doc_cnt % 3 == 0);
      doc_cnt++;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while ((byte_q.size() != 0 || in_valid || token_q.size() != 0) && quiet < STALL_LIMIT)
      @(negedge clk);
    if (quiet < STALL_LIMIT) repeat (TAIL_CYCLES) @(negedge clk);

    if (quiet >= STALL_LIMIT || mismatches != 0) begin
      $display("[FAIL] regression broken");
    end else begin
      $display("[ OK ] regression clean");
    end
    $finish;
  end

endmodule
